@@ src/dfd_pkg.sv @@
// dfd_pkg: shared types and constant functions for the drag force block.
// No dependencies; imported by the register file and the top level.
package dfd_pkg;

  typedef enum logic {
    REG_LINEAR_COEFF    = 1'b0,
    REG_QUADRATIC_COEFF = 1'b1
  } reg_idx_e;

  // APB data bus width for a given datapath width
  function automatic int bus_width(int dw);
    return (dw > 32) ? 64 : 32;
  endfunction

  // APB address width: two registers at stride 4 or 8
  function automatic int addr_width(int dw);
    return (dw > 32) ? 4 : 3;
  endfunction

endpackage

@@ src/dfd_if.sv @@
// dfd_vel_if / dfd_force_if: valid/ready channels for velocity items and force results.
// No dependencies.
interface dfd_vel_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] vel_x;
  logic signed [DATA_WIDTH-1:0] vel_y;

  modport source (output valid, vel_x, vel_y, input ready);
  modport sink   (input valid, vel_x, vel_y, output ready);
endinterface

interface dfd_force_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] force_x;
  logic signed [DATA_WIDTH-1:0] force_y;
  logic                         saturated;

  modport source (output valid, force_x, force_y, saturated, input ready);
  modport sink   (input valid, force_x, force_y, saturated, output ready);
endinterface

@@ src/dfd_apb_regs.sv @@
// dfd_apb_regs: APB register file holding the linear and quadratic drag coefficients.
// Depends on dfd_pkg.
module dfd_apb_regs #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [dfd_pkg::addr_width(DATA_WIDTH)-1:0]    paddr,
  input  logic [dfd_pkg::bus_width(DATA_WIDTH)-1:0]     pwdata,
  output logic [dfd_pkg::bus_width(DATA_WIDTH)-1:0]     prdata,
  output logic                                          pready,
  output logic [DATA_WIDTH-1:0]                         linear_coeff_o,
  output logic [DATA_WIDTH-1:0]                         quadratic_coeff_o
);
  import dfd_pkg::*;

  localparam int BusW  = bus_width(DATA_WIDTH);
  localparam int AddrW = addr_width(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] linear_coeff_q;
  logic [DATA_WIDTH-1:0] quadratic_coeff_q;
  reg_idx_e              idx;
  logic                  wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_coeff_q    <= '0;
      quadratic_coeff_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_LINEAR_COEFF:    linear_coeff_q    <= pwdata[DATA_WIDTH-1:0];
        REG_QUADRATIC_COEFF: quadratic_coeff_q <= pwdata[DATA_WIDTH-1:0];
        default:             linear_coeff_q    <= linear_coeff_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_LINEAR_COEFF:    prdata = BusW'(linear_coeff_q);
      REG_QUADRATIC_COEFF: prdata = BusW'(quadratic_coeff_q);
      default:             prdata = '0;
    endcase
  end

  assign linear_coeff_o    = linear_coeff_q;
  assign quadratic_coeff_o = quadratic_coeff_q;

endmodule

@@ src/dfd_square_front.sv @@
// dfd_square_front: magnitude split, squaring and sum of squares, three elastic stages.
// Depends on dfd_if.
module dfd_square_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dfd_vel_if.sink                   vel_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [2*DATA_WIDTH-1:0]   rad_o,
  output logic [2*DATA_WIDTH+1:0]   side_o
);

  localparam int DW    = DATA_WIDTH;
  localparam int SideW = 2 * DW + 2;

  logic [2:0] v_q;
  logic [2:0] rdy;
  logic [2:0] v_in;

  logic [DW-1:0]    vx_u, vy_u;
  logic [DW-1:0]    mag_x_d, mag_y_d;
  logic [SideW-1:0] side0_q, side1_q, side2_q;
  logic [2*DW-1:0]  sq_x_q, sq_y_q;
  logic [2*DW-1:0]  rad_q;

  assign rdy[2] = ~v_q[2] | ready_i;
  assign rdy[1] = ~v_q[1] | rdy[2];
  assign rdy[0] = ~v_q[0] | rdy[1];
  assign v_in   = {v_q[1:0], vel_i.valid};

  assign vel_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  assign vx_u    = vel_i.vel_x;
  assign vy_u    = vel_i.vel_y;
  assign mag_x_d = vx_u[DW-1] ? (~vx_u + DW'(1)) : vx_u;
  assign mag_y_d = vy_u[DW-1] ? (~vy_u + DW'(1)) : vy_u;

  // side layout: {neg_x, neg_y, mag_x, mag_y}
  always_ff @(posedge clk_i) begin
    if (rdy[0] && v_in[0]) begin
      side0_q <= {vx_u[DW-1], vy_u[DW-1], mag_x_d, mag_y_d};
    end
    if (rdy[1] && v_in[1]) begin
      sq_x_q  <= side0_q[2*DW-1:DW] * side0_q[2*DW-1:DW];
      sq_y_q  <= side0_q[DW-1:0] * side0_q[DW-1:0];
      side1_q <= side0_q;
    end
    if (rdy[2] && v_in[2]) begin
      rad_q   <= sq_x_q + sq_y_q;
      side2_q <= side1_q;
    end
  end

  assign valid_o = v_q[2];
  assign rad_o   = rad_q;
  assign side_o  = side2_q;

endmodule

@@ src/dfd_sqrt_cell.sv @@
// dfd_sqrt_cell: one radix-2 restoring square root step with an elastic output register.
// No dependencies; chained DATA_WIDTH times by the top level.
module dfd_sqrt_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int SIDE_W     = 66
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [2*DATA_WIDTH-1:0]   rad_i,
  input  logic [DATA_WIDTH:0]       rem_i,
  input  logic [DATA_WIDTH-1:0]     root_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [2*DATA_WIDTH-1:0]   rad_o,
  output logic [DATA_WIDTH:0]       rem_o,
  output logic [DATA_WIDTH-1:0]     root_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int DW = DATA_WIDTH;

  logic              valid_q;
  logic              load;
  logic [DW+2:0]     cand, trial, diff;
  logic              take;
  logic [2*DW-1:0]   rad_q;
  logic [DW:0]       rem_q;
  logic [DW-1:0]     root_q;
  logic [SIDE_W-1:0] side_q;

  assign ready_o = ~valid_q | ready_i;
  assign load    = ready_o & valid_i;

  // bring down the next two radicand bits and try root*4+1
  assign cand  = {rem_i, rad_i[2*DW-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign take  = (cand >= trial);
  assign diff  = cand - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rad_q  <= {rad_i[2*DW-3:0], 2'b00};
      rem_q  <= take ? diff[DW:0] : cand[DW:0];
      root_q <= {root_i[DW-2:0], take};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q <= {root_q, 1'b0}))
    else $error("sqrt remainder exceeds twice the partial root");

endmodule

@@ src/dfd_force_pipe.sv @@
// dfd_force_pipe: drag factor, split velocity-by-factor products, rounding and saturation.
// Depends on dfd_if; five elastic stages, the last one is the output register.
module dfd_force_pipe #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [DATA_WIDTH-1:0]     root_i,
  input  logic [2*DATA_WIDTH+1:0]   side_i,
  input  logic [DATA_WIDTH-1:0]     linear_coeff_i,
  input  logic [DATA_WIDTH-1:0]     quadratic_coeff_i,
  dfd_force_if.source               force_o
);

  localparam int DW    = DATA_WIDTH;
  localparam int SideW = 2 * DW + 2;
  localparam int SumW  = 2 * DW + FRAC_BITS;
  localparam int FacW  = DW + FRAC_BITS;
  localparam int LoW   = FacW / 2;
  localparam int HiW   = FacW - LoW;
  localparam int MW    = DW + FacW;
  localparam int NSt   = 5;

  // any factor above this saturates every nonzero component
  localparam logic [SumW-1:0] FacMax = (SumW'(1) << (FacW - 1)) | SumW'(1);
  localparam logic [MW-1:0]   Lim    = MW'(1) << (DW - 1 + FRAC_BITS);
  localparam logic [MW:0]     Rnd    = {{(MW + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic [DW-1:0]   MaxPos = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0]   MinNeg = {1'b1, {(DW - 1){1'b0}}};

  logic [NSt-1:0] v_q, rdy, v_in, load;

  logic [2*DW-1:0]  prod_q;
  logic [SideW-1:0] side_p_q, side_f_q;
  logic [SumW-1:0]  prod_ext, fac_sum;
  logic [FacW-1:0]  factor_q;
  logic [DW-1:0]    mag_x, mag_y;
  logic [DW+LoW-1:0] lo_x_q, lo_y_q;
  logic [DW+HiW-1:0] hi_x_q, hi_y_q;
  logic [1:0]       neg_m_q, neg_s_q;
  logic [MW-1:0]    m_x_q, m_y_q;
  logic [DW:0]      fin_x, fin_y;
  logic [DW-1:0]    force_x_q, force_y_q;
  logic             sat_q;

  // returns {saturated, force}
  function automatic logic [DW:0] finish(logic [MW-1:0] m, logic neg);
    logic [MW:0]   up;
    logic          sat;
    logic [DW-1:0] val;
    up = {1'b0, m} + Rnd;
    if (neg) begin
      sat = (m >= Lim);
      val = sat ? MaxPos : m[FRAC_BITS +: DW];
    end else begin
      sat = (m > Lim);
      val = sat ? MinNeg : (~up[FRAC_BITS +: DW] + DW'(1));
    end
    return {sat, val};
  endfunction

  always_comb begin
    rdy[NSt-1] = ~v_q[NSt-1] | force_o.ready;
    for (int i = NSt - 2; i >= 0; i--) begin
      rdy[i] = ~v_q[i] | rdy[i+1];
    end
  end

  assign v_in    = {v_q[NSt-2:0], valid_i};
  assign load    = rdy & v_in;
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NSt; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  assign prod_ext = SumW'(prod_q);
  assign fac_sum  = (prod_ext >> FRAC_BITS) + SumW'(linear_coeff_i);
  assign mag_x    = side_f_q[2*DW-1:DW];
  assign mag_y    = side_f_q[DW-1:0];
  assign fin_x    = finish(m_x_q, neg_s_q[1]);
  assign fin_y    = finish(m_y_q, neg_s_q[0]);

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      prod_q   <= quadratic_coeff_i * root_i;
      side_p_q <= side_i;
    end
    if (load[1]) begin
      factor_q <= (fac_sum > FacMax) ? FacMax[FacW-1:0] : fac_sum[FacW-1:0];
      side_f_q <= side_p_q;
    end
    if (load[2]) begin
      lo_x_q  <= mag_x * factor_q[LoW-1:0];
      hi_x_q  <= mag_x * factor_q[FacW-1:LoW];
      lo_y_q  <= mag_y * factor_q[LoW-1:0];
      hi_y_q  <= mag_y * factor_q[FacW-1:LoW];
      neg_m_q <= side_f_q[SideW-1:SideW-2];
    end
    if (load[3]) begin
      m_x_q   <= (MW'(hi_x_q) << LoW) + MW'(lo_x_q);
      m_y_q   <= (MW'(hi_y_q) << LoW) + MW'(lo_y_q);
      neg_s_q <= neg_m_q;
    end
    if (load[4]) begin
      force_x_q <= fin_x[DW-1:0];
      force_y_q <= fin_y[DW-1:0];
      sat_q     <= fin_x[DW] | fin_y[DW];
    end
  end

  assign force_o.valid     = v_q[NSt-1];
  assign force_o.force_x   = force_x_q;
  assign force_o.force_y   = force_y_q;
  assign force_o.saturated = sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (factor_q <= FacMax[FacW-1:0]))
    else $error("drag factor above clamp value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NSt-1] && sat_q) |->
      (force_x_q == MaxPos || force_x_q == MinNeg ||
       force_y_q == MaxPos || force_y_q == MinNeg))
    else $error("saturation flag without a clamped component");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && m_x_q == '0 && m_y_q == '0 && load[4]) |=> (!sat_q))
    else $error("zero product reported as saturated");

endmodule

@@ src/drag_force_2d.sv @@
// drag_force_2d: top level of the 2D linear plus quadratic drag force pipeline.
// Depends on dfd_pkg, dfd_if, dfd_apb_regs, dfd_square_front, dfd_sqrt_cell, dfd_force_pipe.
//
// Each velocity transfer yields one force transfer, in order. Speed is the truncated square
// root of vel_x^2 + vel_y^2, the factor is k1 + k2*speed, force = -vel*factor, all in
// fixed point with FRAC_BITS fraction bits, clamped to the signed range (saturated flags it).
// The block takes one transfer per cycle unless a sink stall holds the pipeline. It has three
// front stages for magnitudes and squares, one cell per root bit in the square root chain,
// and five stages for product, factor, split products, their sum and rounding into the
// output register. Every stage has its own valid bit, so bubbles close up when the sink
// stalls. Coefficients sit at APB offsets 0 (linear) and 4 (quadratic), or 0 and 8 with a
// 64-bit bus when DATA_WIDTH is above 32; write them only while no transfer is in flight.
module drag_force_2d #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [dfd_pkg::addr_width(DATA_WIDTH)-1:0]    paddr,
  input  logic [dfd_pkg::bus_width(DATA_WIDTH)-1:0]     pwdata,
  output logic [dfd_pkg::bus_width(DATA_WIDTH)-1:0]     prdata,
  output logic                                          pready,
  dfd_vel_if.sink                                       vel_i,
  dfd_force_if.source                                   force_o
);
  import dfd_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int SideW = 2 * DW + 2;

  logic [DW-1:0] linear_coeff, quadratic_coeff;

  logic                cv   [DW+1];
  logic                cr   [DW+1];
  logic [2*DW-1:0]     rad  [DW+1];
  logic [DW:0]         rem  [DW+1];
  logic [DW-1:0]       root [DW+1];
  logic [SideW-1:0]    side [DW+1];

  dfd_apb_regs #(
    .DATA_WIDTH (DW)
  ) u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .linear_coeff_o    (linear_coeff),
    .quadratic_coeff_o (quadratic_coeff)
  );

  dfd_square_front #(
    .DATA_WIDTH (DW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vel_i   (vel_i),
    .valid_o (cv[0]),
    .ready_i (cr[0]),
    .rad_o   (rad[0]),
    .side_o  (side[0])
  );

  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar g = 0; g < DW; g++) begin : g_cell
    dfd_sqrt_cell #(
      .DATA_WIDTH (DW),
      .SIDE_W     (SideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .ready_o (cr[g]),
      .rad_i   (rad[g]),
      .rem_i   (rem[g]),
      .root_i  (root[g]),
      .side_i  (side[g]),
      .valid_o (cv[g+1]),
      .ready_i (cr[g+1]),
      .rad_o   (rad[g+1]),
      .rem_o   (rem[g+1]),
      .root_o  (root[g+1]),
      .side_o  (side[g+1])
    );
  end

  dfd_force_pipe #(
    .DATA_WIDTH (DW),
    .FRAC_BITS  (FRAC_BITS)
  ) u_force (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (cv[DW]),
    .ready_o           (cr[DW]),
    .root_i            (root[DW]),
    .side_i            (side[DW]),
    .linear_coeff_i    (linear_coeff),
    .quadratic_coeff_i (quadratic_coeff),
    .force_o           (force_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for drag_force_2d, with directed and random velocity streams.
// Depends on dfd_pkg, dfd_if and the drag_force_2d RTL; builds its expected forces itself.
// Random stalls on both channels; coefficients are changed over APB between phases.
module tb_top;
  import dfd_pkg::*;

  localparam int DW          = 32;
  localparam int FB          = 16;
  localparam int BUS_W       = bus_width(DW);
  localparam int ADDR_W      = addr_width(DW);
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [DW-1:0] COEFF_MAX = '1;
  localparam logic [DW-1:0] ONE_Q     = 32'h0001_0000;
  localparam logic [DW-1:0] VEL_MAX   = 32'h7fff_ffff;
  localparam logic [DW-1:0] VEL_MIN   = 32'h8000_0000;

  typedef struct packed {
    logic [DW-1:0] fx;
    logic [DW-1:0] fy;
    logic          sat;
  } drag_result_t;

  logic              clk_i = 1'b0;
  logic              rst_n;
  logic              apb_psel;
  logic              apb_penable;
  logic              apb_pwrite;
  logic [ADDR_W-1:0] apb_paddr;
  logic [BUS_W-1:0]  apb_pwdata;
  logic [BUS_W-1:0]  apb_prdata;
  logic              apb_pready;

  dfd_vel_if   #(.DATA_WIDTH(DW)) vel_bus ();
  dfd_force_if #(.DATA_WIDTH(DW)) force_bus ();

  drag_force_2d #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_n),
    .psel    (apb_psel),
    .penable (apb_penable),
    .pwrite  (apb_pwrite),
    .paddr   (apb_paddr),
    .pwdata  (apb_pwdata),
    .prdata  (apb_prdata),
    .pready  (apb_pready),
    .vel_i   (vel_bus),
    .force_o (force_bus)
  );

  logic [DW-1:0] k1_model;
  logic [DW-1:0] k2_model;
  drag_result_t  pending_forces_q[$];
  drag_result_t  oldest_force;
  logic          idle_enable;
  int unsigned   stall_left;
  int unsigned   cycle_count;
  int unsigned   mismatch_count;
  int unsigned   vel_sent;
  int unsigned   forces_seen;
  int unsigned   sat_predicted;
  int unsigned   coeff_settings;

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [DW:0] vel_magnitude(logic [DW-1:0] v);
    logic [DW:0] ext;
    ext = {v[DW-1], v};
    return v[DW-1] ? (~ext + 1'b1) : ext;
  endfunction

  function automatic logic [DW:0] speed_isqrt(logic [127:0] n);
    logic [DW:0]  root;
    logic [DW:0]  cand;
    logic [127:0] cand_w;
    root = '0;
    for (int b = DW; b >= 0; b--) begin
      cand   = root | ((DW+1)'(1) << b);
      cand_w = 128'(cand);
      if (cand_w * cand_w <= n) root = cand;
    end
    return root;
  endfunction

  // neg is the sign of the velocity; the force takes the opposite sign
  function automatic logic [DW-1:0] drag_component(logic [DW:0] mag, logic neg,
                                                   logic [127:0] factor, inout logic sat);
    logic [127:0] prod;
    logic [127:0] lim;
    logic [127:0] up;
    if (mag == '0) return '0;
    prod = 128'(mag) * factor;
    lim  = 128'd1 << (DW - 1 + FB);
    if (neg) begin
      if (prod >= lim) begin
        sat = 1'b1;
        return VEL_MAX;
      end
      return DW'(prod >> FB);
    end
    if (prod > lim) begin
      sat = 1'b1;
      return VEL_MIN;
    end
    up = (prod + ((128'd1 << FB) - 1)) >> FB;
    return DW'(128'd0 - up);
  endfunction

  function automatic drag_result_t predict_drag(logic [DW-1:0] vx, logic [DW-1:0] vy);
    drag_result_t res;
    logic [DW:0]  mx;
    logic [DW:0]  my;
    logic [DW:0]  speed;
    logic [127:0] factor;
    logic         sat;
    mx     = vel_magnitude(vx);
    my     = vel_magnitude(vy);
    speed  = speed_isqrt(128'(mx) * 128'(mx) + 128'(my) * 128'(my));
    factor = ((128'(k2_model) * 128'(speed)) >> FB) + 128'(k1_model);
    if (factor > (128'd1 << (DW + FB))) factor = 128'd1 << (DW + FB);
    sat    = 1'b0;
    res.fx = drag_component(mx, vx[DW-1], factor, sat);
    res.fy = drag_component(my, vy[DW-1], factor, sat);
    res.sat = sat;
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_velocity(input logic [DW-1:0] vx, input logic [DW-1:0] vy);
    drag_result_t exp_force;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      vel_bus.valid <= 1'b0;
      vel_bus.vel_x <= $urandom;
      vel_bus.vel_y <= $urandom;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    vel_bus.valid <= 1'b1;
    vel_bus.vel_x <= vx;
    vel_bus.vel_y <= vy;
    do @(posedge clk_i); while (!vel_bus.ready);
    exp_force = predict_drag(vx, vy);
    pending_forces_q.insert(pending_forces_q.size(), exp_force);
    vel_sent++;
    if (exp_force.sat) sat_predicted++;
  endtask

  // drops valid in the step of the last transfer, then waits for every force
  task automatic drain_forces();
    vel_bus.valid <= 1'b0;
    while (pending_forces_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic apb_access(input reg_idx_e idx, input logic write,
                            input logic [DW-1:0] wdata, output logic [BUS_W-1:0] rdata);
    apb_psel    <= 1'b1;
    apb_penable <= 1'b0;
    apb_pwrite  <= write;
    apb_paddr   <= ADDR_W'(int'(idx) * (BUS_W / 8));
    apb_pwdata  <= BUS_W'(wdata);
    @(posedge clk_i);
    apb_penable <= 1'b1;
    do @(posedge clk_i); while (!apb_pready);
    rdata = apb_prdata;
    apb_psel    <= 1'b0;
    apb_penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_coeff(input reg_idx_e idx, input logic [DW-1:0] value);
    logic [BUS_W-1:0] rdata;
    apb_access(idx, 1'b1, value, rdata);
    case (idx)
      REG_LINEAR_COEFF: begin
        k1_model = value;
      end
      REG_QUADRATIC_COEFF: begin
        k2_model = value;
      end
      default: begin
      end
    endcase
    apb_access(idx, 1'b0, '0, rdata);
    if (DW'(rdata) !== value)
      report_mismatch($sformatf("%s readback %h, wrote %h", idx.name(), rdata, value));
  endtask

  task automatic set_coefficients(input logic [DW-1:0] k1, input logic [DW-1:0] k2);
    drain_forces();
    write_coeff(REG_LINEAR_COEFF, k1);
    write_coeff(REG_QUADRATIC_COEFF, k2);
    coeff_settings++;
  endtask

  function automatic logic [DW-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COEFF_MAX;
      2:       return DW'($urandom_range(0, 32'h0003_ffff));
      3:       return DW'($urandom);
      default: return DW'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_velocity();
    int signed v;
    case ($urandom_range(0, 7))
      0: return '0;
      1: begin
        v = $urandom_range(0, 32'h000f_ffff);
        return DW'(v - 32'sh0008_0000);
      end
      2, 3: return DW'($urandom);
      4: begin
        case ($urandom_range(0, 3))
          0:       return VEL_MAX;
          1:       return VEL_MIN;
          2:       return '1;
          default: return DW'(1);
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'h01ff_ffff);
        return DW'(v - 32'sh0100_0000);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- result checker

  always @(posedge clk_i) begin
    if (rst_n && force_bus.valid && force_bus.ready) begin
      forces_seen++;
      if (pending_forces_q.size() == 0) begin
        report_mismatch($sformatf("force transfer with nothing pending: %h %h %b",
                                  force_bus.force_x, force_bus.force_y, force_bus.saturated));
      end else begin
        oldest_force = pending_forces_q.pop_front();
        if (force_bus.force_x !== oldest_force.fx)
          report_mismatch($sformatf("force_x %h, expected %h",
                                    force_bus.force_x, oldest_force.fx));
        if (force_bus.force_y !== oldest_force.fy)
          report_mismatch($sformatf("force_y %h, expected %h",
                                    force_bus.force_y, oldest_force.fy));
        if (force_bus.saturated !== oldest_force.sat)
          report_mismatch($sformatf("saturated %b, expected %b",
                                    force_bus.saturated, oldest_force.sat));
      end
    end
    if (!idle_enable) begin
      force_bus.ready <= 1'b1;
    end else if (stall_left != 0) begin
      force_bus.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      force_bus.ready <= 1'b0;
      stall_left      <= $urandom_range(0, 9);
    end else begin
      force_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d forces pending", cycle_count,
               pending_forces_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_coeffs();
    send_velocity('0, '0);
    send_velocity(VEL_MAX, VEL_MIN);
    send_velocity('1, DW'(1));
  endtask

  task automatic test_linear_drag();
    set_coefficients(ONE_Q, '0);
    send_velocity(VEL_MIN, VEL_MAX);
    send_velocity(DW'(1), '1);
    send_velocity('0, DW'(5));
    send_velocity('1, '0);
    send_velocity('0, '0);
    send_velocity(32'h0002_8000, 32'hfffd_8000);
  endtask

  task automatic test_quadratic_drag();
    set_coefficients('0, ONE_Q);
    send_velocity(32'h0003_0000, 32'h0004_0000);
    send_velocity(32'hfffd_0000, 32'hfffc_0000);
    send_velocity(32'h0100_0000, '0);
    send_velocity(VEL_MIN, VEL_MIN);
    send_velocity(32'h0000_0001, 32'h0000_0003);
  endtask

  task automatic test_saturation();
    set_coefficients(COEFF_MAX, COEFF_MAX);
    send_velocity(DW'(1), '0);
    send_velocity('0, '0);
    send_velocity(VEL_MAX, VEL_MIN);
    send_velocity('1, '1);
    set_coefficients(32'h0040_0000, '0);
    send_velocity(32'h0200_0000, 32'hfe00_0000);
    send_velocity(32'h0200_0001, 32'hfdff_ffff);
    send_velocity(32'h01ff_ffff, '0);
  endtask

  task automatic test_random_phases(input int unsigned phases, input int unsigned per_phase);
    for (int unsigned p = 0; p < phases; p++) begin
      if (p == phases - 1) begin
        set_coefficients(pick_coeff(), pick_coeff());
        idle_enable = 1'b0;
      end else begin
        set_coefficients(pick_coeff(), pick_coeff());
      end
      for (int unsigned i = 0; i < per_phase; i++) send_velocity(pick_velocity(), pick_velocity());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    apb_psel       = 1'b0;
    apb_penable    = 1'b0;
    apb_pwrite     = 1'b0;
    apb_paddr      = '0;
    apb_pwdata     = '0;
    vel_bus.valid  = 1'b0;
    vel_bus.vel_x  = '0;
    vel_bus.vel_y  = '0;
    force_bus.ready = 1'b0;
    k1_model       = '0;
    k2_model       = '0;
    idle_enable    = 1'b1;
    stall_left     = 0;
    cycle_count    = 0;
    mismatch_count = 0;
    vel_sent       = 0;
    forces_seen    = 0;
    sat_predicted  = 0;
    coeff_settings = 0;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_coeffs();
    test_linear_drag();
    test_quadratic_drag();
    test_saturation();
    test_random_phases(10, 65);

    drain_forces();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d velocity transfers and %0d force transfers", vel_sent, forces_seen);
    $display("over %0d coefficient settings, %0d saturated; %0d mismatches",
             coeff_settings, sat_predicted, mismatch_count);
    if (mismatch_count == 0 && pending_forces_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
